[rtl/kalman_tracker_constant_velocity_2d_unit_assert.svh]
// assertion macros for the kalman tracker checker
// depends on nothing; expects clk and rst_n in the including scope
`ifndef KALMAN_TRACKER_CONSTANT_VELOCITY_2D_UNIT_ASSERT_SVH
`define KALMAN_TRACKER_CONSTANT_VELOCITY_2D_UNIT_ASSERT_SVH

// same-cycle implication
`define KT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kt_pkg.sv]
// shared types, constants and clamp helpers for the kalman tracker
// no dependencies
package kt_pkg;

    localparam int STATE_FRAC_BITS = 16;
    localparam int COV_FRAC_BITS   = 24;
    localparam int MAX_DT_US       = 16777215;
    localparam int NOISE_FRAC      = 16;
    localparam int WORD_W          = 64;
    localparam int PROD_W          = 128;
    localparam int MAG_W           = 61;
    localparam int SH_W            = 6;
    localparam int DELTA_W         = $clog2(MAX_DT_US + 1);
    localparam int CFG_IDX_W       = 3;

    localparam logic [WORD_W-1:0] US_PER_SECOND = 64'd1000000;
    localparam logic [MAG_W-1:0]  WIDE_LIM      = {1'b1, {(MAG_W-1){1'b0}}};

    localparam logic signed [WORD_W-1:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [WORD_W-1:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [WORD_W-1:0] VAR_MAX = 64'sd281474976710655;
    localparam logic signed [WORD_W-1:0] COV_MIN = -64'sd140737488355328;
    localparam logic signed [WORD_W-1:0] COV_MAX = 64'sd140737488355327;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_POS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VEL = 3'd4;

    typedef enum logic [0:0] {OP_MUL_SHIFT, OP_MUL_DIV} arith_op_t;

    typedef struct packed {
        logic            start;
        arith_op_t       op;
        logic [SH_W-1:0] sh;
    } arith_req_t;

    typedef struct packed {
        logic done;
        logic sat;
    } arith_rsp_t;

    typedef enum logic [2:0] {
        AU_IDLE, AU_MUL, AU_MRND, AU_DCHK, AU_DIV, AU_DRND, AU_DONE
    } au_state_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DT, ST_DT2, ST_DT3, ST_DT4, ST_LOAD, ST_QPP, ST_QPV, ST_QVV,
        ST_PM, ST_TM, ST_PP1, ST_PP2, ST_PRED, ST_K1, ST_K2, ST_U1, ST_U2, ST_U3,
        ST_STORE, ST_OUT
    } seq_state_t;

    function automatic logic over_s32(input logic signed [WORD_W-1:0] v);
        return (v < S32_MIN) || (v > S32_MAX);
    endfunction

    function automatic logic signed [31:0] clamp_s32(input logic signed [WORD_W-1:0] v);
        logic signed [WORD_W-1:0] c;
        c = (v < S32_MIN) ? S32_MIN : ((v > S32_MAX) ? S32_MAX : v);
        return c[31:0];
    endfunction

    function automatic logic over_var(input logic signed [WORD_W-1:0] v);
        return (v < 0) || (v > VAR_MAX);
    endfunction

    function automatic logic [47:0] clamp_var(input logic signed [WORD_W-1:0] v);
        logic signed [WORD_W-1:0] c;
        c = (v < 0) ? '0 : ((v > VAR_MAX) ? VAR_MAX : v);
        return c[47:0];
    endfunction

    function automatic logic over_cov(input logic signed [WORD_W-1:0] v);
        return (v < COV_MIN) || (v > COV_MAX);
    endfunction

    function automatic logic signed [47:0] clamp_cov(input logic signed [WORD_W-1:0] v);
        logic signed [WORD_W-1:0] c;
        c = (v < COV_MIN) ? COV_MIN : ((v > COV_MAX) ? COV_MAX : v);
        return c[47:0];
    endfunction

endpackage

[rtl/kt_arith.sv]
// shared multiply / multiply-divide unit with rounding and wide clamp
// depends on kt_pkg
module kt_arith (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kt_pkg::arith_req_t                req,
    input  logic signed [kt_pkg::WORD_W-1:0]  opa,
    input  logic signed [kt_pkg::WORD_W-1:0]  opb,
    input  logic        [kt_pkg::WORD_W-1:0]  divisor,
    output kt_pkg::arith_rsp_t                rsp,
    output logic signed [kt_pkg::WORD_W-1:0]  res
);
    import kt_pkg::*;

    au_state_t           state_reg, state_next;
    arith_op_t           op_reg;
    logic [SH_W-1:0]     sh_reg;
    logic [WORD_W-1:0]   ma_reg, mb_reg, d_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [1:0]          pk_reg;
    logic [5:0]          cnt_reg;
    logic                neg_reg, sat_reg;
    logic [MAG_W-1:0]    mag_reg;

    logic [31:0]         pa, pb;
    logic [WORD_W-1:0]   pp;
    logic [PROD_W-1:0]   pp_sh;
    logic [PROD_W:0]     rnd_sum, rnd_shr;
    logic [WORD_W:0]     rem65, diff65;
    logic                ge;
    logic [WORD_W-1:0]   q_rnd, rem_w;
    logic [WORD_W-1:0]   magw;

    always_comb
    begin
        pa = pk_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        pb = pk_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp = pa * pb;
        case (pk_reg)
            2'd0:    pp_sh = {64'b0, pp};
            2'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = {32'b0, pp, 32'b0};
        endcase
        rnd_sum = {1'b0, acc_reg} + ((PROD_W+1)'(1) << (sh_reg - SH_W'(1)));
        rnd_shr = rnd_sum >> sh_reg;
        rem65   = {acc_reg[127:64], acc_reg[63]};
        diff65  = rem65 - {1'b0, d_reg};
        ge      = rem65 >= {1'b0, d_reg};
        rem_w   = acc_reg[127:64];
        q_rnd   = ((rem_w >= (d_reg - rem_w)) && (acc_reg[63:0] != '1))
                  ? acc_reg[63:0] + WORD_W'(1) : acc_reg[63:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            AU_IDLE: if (req.start) state_next = AU_MUL;
            AU_MUL:  if (pk_reg == 2'd3) state_next = (op_reg == OP_MUL_DIV) ? AU_DCHK : AU_MRND;
            AU_MRND: state_next = AU_DONE;
            AU_DCHK: state_next = (acc_reg[127:64] >= d_reg) ? AU_DONE : AU_DIV;
            AU_DIV:  if (cnt_reg == 6'd63) state_next = AU_DRND;
            AU_DRND: state_next = AU_DONE;
            AU_DONE: state_next = AU_IDLE;
            default: state_next = AU_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AU_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            AU_IDLE:
            begin
                if (req.start)
                begin
                    ma_reg  <= opa[63] ? WORD_W'(-opa) : WORD_W'(opa);
                    mb_reg  <= opb[63] ? WORD_W'(-opb) : WORD_W'(opb);
                    neg_reg <= opa[63] ^ opb[63];
                    op_reg  <= req.op;
                    sh_reg  <= req.sh;
                    d_reg   <= divisor;
                    acc_reg <= '0;
                    pk_reg  <= '0;
                    cnt_reg <= '0;
                    sat_reg <= 1'b0;
                end
            end
            AU_MUL:
            begin
                acc_reg <= acc_reg + pp_sh;
                pk_reg  <= pk_reg + 2'd1;
            end
            AU_MRND:
            begin
                if (rnd_shr > (PROD_W+1)'(WIDE_LIM))
                begin
                    mag_reg <= WIDE_LIM;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    mag_reg <= rnd_shr[MAG_W-1:0];
                end
            end
            AU_DCHK:
            begin
                if (acc_reg[127:64] >= d_reg)
                begin
                    mag_reg <= WIDE_LIM;
                    sat_reg <= 1'b1;
                end
            end
            AU_DIV:
            begin
                acc_reg <= {(ge ? diff65[63:0] : rem65[63:0]), acc_reg[62:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
            end
            AU_DRND:
            begin
                if (q_rnd > WORD_W'(WIDE_LIM))
                begin
                    mag_reg <= WIDE_LIM;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    mag_reg <= q_rnd[MAG_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        magw     = {3'b0, mag_reg};
        rsp.done = (state_reg == AU_DONE);
        rsp.sat  = sat_reg;
        res      = neg_reg ? -$signed(magw) : $signed(magw);
    end

endmodule

[rtl/kalman_tracker_constant_velocity_2d_unit.sv]
// two-axis constant-velocity kalman tracker, sequencer and state
// depends on kt_pkg and kt_arith
//
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    timestamp_us, meas_px, meas_py
// m_*      out  m_tvalid / m_tready    state, covariance, flags in tuser
// cfg_*    in   cfg_valid / cfg_ready  register index and value
//
// first item after reset initialises the state, no result
// later items each take 17 multiplies and up to 11 multiply-divides,
// all on the one shared unit
// the divide works out one quotient bit per cycle
// a result waits in the output register while the next item is taken
// reset clears control state and sets configuration to its defaults; cfg_ready is always high
module kalman_tracker_constant_velocity_2d_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [127:0]                  s_tdata,   // timestamp_us, meas_px, meas_py, pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [415:0]                  m_tdata,   // est_px, est_py, est_vx, est_vy, var_px,
                                                     // var_py, var_vx, var_vy, cov_px_vx, cov_py_vy
    output logic [1:0]                    m_tuser,   // dt_clamped, saturated
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [47:0]                   cfg_data
);
    import kt_pkg::*;

    seq_state_t state_reg, state_next;

    logic [31:0] accel_x_reg, accel_y_reg;
    logic [47:0] meas_var_reg, init_pos_reg, init_vel_reg;

    logic                      init_reg, ax_reg, issued_reg, sat_reg, dclamp_reg;
    logic [62:0]               last_ts_reg;
    logic [DELTA_W-1:0]        delta_reg;
    logic signed [31:0]        zx_reg, zy_reg;
    logic signed [31:0]        px_reg, py_reg, vx_reg, vy_reg;
    logic [47:0]               ppx_reg, ppy_reg, vvx_reg, vvy_reg;
    logic signed [47:0]        pvx_reg, pvy_reg;

    logic signed [WORD_W-1:0]  dt_reg, dt2_reg, dt3_reg, dt4_reg;
    logic signed [WORD_W-1:0]  qpp_reg, qpv_reg, qvv_reg, t_reg, acc_reg;
    logic signed [31:0]        p_reg, v_reg;
    logic [47:0]               pp_reg, vv_reg, npp_reg, nvv_reg;
    logic signed [47:0]        pv_reg, npv_reg;
    logic [48:0]               s_reg;
    logic signed [33:0]        y_reg;

    logic                      out_valid_reg, out_dclamp_reg, out_sat_reg;
    logic signed [31:0]        o_px_reg, o_py_reg, o_vx_reg, o_vy_reg;
    logic [47:0]               o_ppx_reg, o_ppy_reg, o_vvx_reg, o_vvy_reg;
    logic signed [47:0]        o_pvx_reg, o_pvy_reg;

    arith_req_t                req;
    arith_rsp_t                rsp;
    logic signed [WORD_W-1:0]  opa, opb, res;
    logic [WORD_W-1:0]         divisor;

    logic [62:0]               ts_in, ts_diff;
    logic signed [31:0]        zx_in, zy_in, z_sel;
    logic [DELTA_W-1:0]        delta_c;
    logic                      dclamp_c, accept, arith_st, out_load, sat_hit;
    logic [31:0]               accel_sel;
    logic signed [WORD_W-1:0]  p_ext, v_ext, pp_ext, vv_ext, pv_ext, npv_ext;
    logic signed [WORD_W-1:0]  npp_sum, npv_sum, nvv_sum, sum_a;
    logic [47:0]               npp_c;
    logic [48:0]               s_c;

    kt_arith u_arith (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .opa     (opa),
        .opb     (opb),
        .divisor (divisor),
        .rsp     (rsp),
        .res     (res)
    );

    always_comb
    begin
        ts_in    = s_tdata[62:0];
        zx_in    = s_tdata[94:63];
        zy_in    = s_tdata[126:95];
        ts_diff  = ts_in - last_ts_reg;
        if (ts_in < last_ts_reg)
        begin
            delta_c  = '0;
            dclamp_c = 1'b1;
        end
        else if (ts_diff > 63'(MAX_DT_US))
        begin
            delta_c  = DELTA_W'(MAX_DT_US);
            dclamp_c = 1'b1;
        end
        else
        begin
            delta_c  = ts_diff[DELTA_W-1:0];
            dclamp_c = 1'b0;
        end
        accept    = s_tvalid && s_tready;
        out_load  = !out_valid_reg || m_tready;
        arith_st  = state_reg inside {ST_DT, ST_DT2, ST_DT3, ST_DT4, ST_QPP, ST_QPV,
                                      ST_QVV, ST_PM, ST_TM, ST_PP1, ST_PP2, ST_K1,
                                      ST_K2, ST_U1, ST_U2, ST_U3};
        accel_sel = ax_reg ? accel_y_reg : accel_x_reg;
        z_sel     = ax_reg ? zy_reg : zx_reg;
        p_ext     = WORD_W'(p_reg);
        v_ext     = WORD_W'(v_reg);
        pp_ext    = $signed({16'b0, pp_reg});
        vv_ext    = $signed({16'b0, vv_reg});
        pv_ext    = WORD_W'(pv_reg);
        npv_ext   = WORD_W'(npv_reg);
        npp_sum   = acc_reg + qpp_reg;
        npv_sum   = t_reg + qpv_reg;
        nvv_sum   = vv_ext + qvv_reg;
        npp_c     = clamp_var(npp_sum);
        s_c       = {1'b0, npp_c} + {1'b0, meas_var_reg};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept && init_reg) state_next = ST_DT;
            ST_DT:    if (rsp.done) state_next = ST_DT2;
            ST_DT2:   if (rsp.done) state_next = ST_DT3;
            ST_DT3:   if (rsp.done) state_next = ST_DT4;
            ST_DT4:   if (rsp.done) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_QPP;
            ST_QPP:   if (rsp.done) state_next = ST_QPV;
            ST_QPV:   if (rsp.done) state_next = ST_QVV;
            ST_QVV:   if (rsp.done) state_next = ST_PM;
            ST_PM:    if (rsp.done) state_next = ST_TM;
            ST_TM:    if (rsp.done) state_next = ST_PP1;
            ST_PP1:   if (rsp.done) state_next = ST_PP2;
            ST_PP2:   if (rsp.done) state_next = ST_PRED;
            ST_PRED:  state_next = (s_c == '0) ? ST_STORE : ST_K1;
            ST_K1:    if (rsp.done) state_next = ST_K2;
            ST_K2:    if (rsp.done) state_next = ST_U1;
            ST_U1:    if (rsp.done) state_next = ST_U2;
            ST_U2:    if (rsp.done) state_next = ST_U3;
            ST_U3:    if (rsp.done) state_next = ST_STORE;
            ST_STORE: state_next = ax_reg ? ST_OUT : ST_LOAD;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: unit operands
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        req.start = arith_st && !issued_reg;
        req.op    = OP_MUL_SHIFT;
        req.sh    = SH_W'(COV_FRAC_BITS);
        opa       = dt_reg;
        opb       = dt_reg;
        divisor   = {15'b0, s_reg};
        case (state_reg)
            ST_DT:
            begin
                req.op  = OP_MUL_DIV;
                opa     = $signed(WORD_W'(delta_reg));
                opb     = $signed(WORD_W'(1) << COV_FRAC_BITS);
                divisor = US_PER_SECOND;
            end
            ST_DT3:   opa = dt2_reg;
            ST_DT4:   opa = dt3_reg;
            ST_QPP:
            begin
                opa    = dt4_reg;
                opb    = $signed({32'b0, accel_sel});
                req.sh = SH_W'(NOISE_FRAC + 2);
            end
            ST_QPV:
            begin
                opa    = dt3_reg;
                opb    = $signed({32'b0, accel_sel});
                req.sh = SH_W'(NOISE_FRAC + 1);
            end
            ST_QVV:
            begin
                opa    = dt2_reg;
                opb    = $signed({32'b0, accel_sel});
                req.sh = SH_W'(NOISE_FRAC);
            end
            ST_PM:    opb = v_ext;
            ST_TM:    opb = vv_ext;
            ST_PP1:   opb = pv_ext;
            ST_PP2:   opb = t_reg;
            ST_K1:
            begin
                req.op = OP_MUL_DIV;
                opa    = WORD_W'(y_reg);
                opb    = $signed({16'b0, npp_reg});
            end
            ST_K2:
            begin
                req.op = OP_MUL_DIV;
                opa    = WORD_W'(y_reg);
                opb    = npv_ext;
            end
            ST_U1:
            begin
                req.op = OP_MUL_DIV;
                opa    = $signed({16'b0, npp_reg});
                opb    = $signed({16'b0, meas_var_reg});
            end
            ST_U2:
            begin
                req.op = OP_MUL_DIV;
                opa    = npv_ext;
                opb    = $signed({16'b0, meas_var_reg});
            end
            ST_U3:
            begin
                req.op = OP_MUL_DIV;
                opa    = npv_ext;
                opb    = npv_ext;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_PM, ST_K1: sum_a = p_ext + res;
            ST_K2:        sum_a = v_ext + res;
            ST_U3:        sum_a = $signed({16'b0, nvv_reg}) - res;
            default:      sum_a = res;
        endcase
    end

    // any clamp in this cycle
    always_comb
    begin
        sat_hit = rsp.done && arith_st && rsp.sat;
        case (state_reg)
            ST_PM, ST_K1, ST_K2:
                if (rsp.done && over_s32(sum_a)) sat_hit = 1'b1;
            ST_PRED:
                if (over_var(npp_sum) || over_cov(npv_sum) || over_var(nvv_sum))
                    sat_hit = 1'b1;
            ST_U1, ST_U3:
                if (rsp.done && over_var(sum_a)) sat_hit = 1'b1;
            ST_U2:
                if (rsp.done && over_cov(sum_a)) sat_hit = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            accel_x_reg   <= 32'd327680;
            accel_y_reg   <= 32'd327680;
            meas_var_reg  <= 48'd377487;
            init_pos_reg  <= 48'd16777216;
            init_vel_reg  <= 48'd16777216000;
            init_reg      <= 1'b0;
            last_ts_reg   <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            ax_reg        <= 1'b0;
            issued_reg    <= 1'b0;
            sat_reg       <= 1'b0;
            dclamp_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ACCEL_X:  accel_x_reg  <= cfg_data[31:0];
                    CFG_ACCEL_Y:  accel_y_reg  <= cfg_data[31:0];
                    CFG_MEAS_VAR: meas_var_reg <= cfg_data;
                    CFG_INIT_POS: init_pos_reg <= cfg_data;
                    CFG_INIT_VEL: init_vel_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (req.start)
                issued_reg <= 1'b1;
            else if (rsp.done)
                issued_reg <= 1'b0;

            if (state_reg == ST_OUT && out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            if (sat_hit)
                sat_reg <= 1'b1;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_ts_reg <= ts_in;
                        if (!init_reg)
                        begin
                            init_reg <= 1'b1;
                            px_reg   <= zx_in;
                            py_reg   <= zy_in;
                            vx_reg   <= '0;
                            vy_reg   <= '0;
                        end
                        else
                        begin
                            dclamp_reg <= dclamp_c;
                            sat_reg    <= 1'b0;
                            ax_reg     <= 1'b0;
                        end
                    end
                end
                ST_STORE:
                begin
                    ax_reg <= 1'b1;
                    if (ax_reg)
                    begin
                        py_reg <= p_reg;
                        vy_reg <= v_reg;
                    end
                    else
                    begin
                        px_reg <= p_reg;
                        vx_reg <= v_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    delta_reg <= delta_c;
                    zx_reg    <= zx_in;
                    zy_reg    <= zy_in;
                    if (!init_reg)
                    begin
                        ppx_reg <= init_pos_reg;
                        ppy_reg <= init_pos_reg;
                        vvx_reg <= init_vel_reg;
                        vvy_reg <= init_vel_reg;
                        pvx_reg <= '0;
                        pvy_reg <= '0;
                    end
                end
            end
            ST_DT:   if (rsp.done) dt_reg  <= res;
            ST_DT2:  if (rsp.done) dt2_reg <= res;
            ST_DT3:  if (rsp.done) dt3_reg <= res;
            ST_DT4:  if (rsp.done) dt4_reg <= res;
            ST_LOAD:
            begin
                p_reg  <= ax_reg ? py_reg  : px_reg;
                v_reg  <= ax_reg ? vy_reg  : vx_reg;
                pp_reg <= ax_reg ? ppy_reg : ppx_reg;
                vv_reg <= ax_reg ? vvy_reg : vvx_reg;
                pv_reg <= ax_reg ? pvy_reg : pvx_reg;
            end
            ST_QPP:  if (rsp.done) qpp_reg <= res;
            ST_QPV:  if (rsp.done) qpv_reg <= res;
            ST_QVV:  if (rsp.done) qvv_reg <= res;
            ST_PM:   if (rsp.done) p_reg   <= clamp_s32(sum_a);
            ST_TM:   if (rsp.done) t_reg   <= pv_ext + res;
            ST_PP1:  if (rsp.done) acc_reg <= pp_ext + res;
            ST_PP2:  if (rsp.done) acc_reg <= acc_reg + res;
            ST_PRED:
            begin
                npp_reg <= npp_c;
                npv_reg <= clamp_cov(npv_sum);
                nvv_reg <= clamp_var(nvv_sum);
                pp_reg  <= npp_c;
                pv_reg  <= clamp_cov(npv_sum);
                vv_reg  <= clamp_var(nvv_sum);
                s_reg   <= s_c;
                y_reg   <= 34'(z_sel) - 34'(p_reg);
            end
            ST_K1:   if (rsp.done) p_reg  <= clamp_s32(sum_a);
            ST_K2:   if (rsp.done) v_reg  <= clamp_s32(sum_a);
            ST_U1:   if (rsp.done) pp_reg <= clamp_var(sum_a);
            ST_U2:   if (rsp.done) pv_reg <= clamp_cov(sum_a);
            ST_U3:   if (rsp.done) vv_reg <= clamp_var(sum_a);
            ST_STORE:
            begin
                if (ax_reg)
                begin
                    ppy_reg <= pp_reg;
                    vvy_reg <= vv_reg;
                    pvy_reg <= pv_reg;
                end
                else
                begin
                    ppx_reg <= pp_reg;
                    vvx_reg <= vv_reg;
                    pvx_reg <= pv_reg;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    o_px_reg       <= px_reg;
                    o_py_reg       <= py_reg;
                    o_vx_reg       <= vx_reg;
                    o_vy_reg       <= vy_reg;
                    o_ppx_reg      <= ppx_reg;
                    o_ppy_reg      <= ppy_reg;
                    o_vvx_reg      <= vvx_reg;
                    o_vvy_reg      <= vvy_reg;
                    o_pvx_reg      <= pvx_reg;
                    o_pvy_reg      <= pvy_reg;
                    out_dclamp_reg <= dclamp_reg;
                    out_sat_reg    <= sat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {o_pvy_reg, o_pvx_reg, o_vvy_reg, o_vvx_reg, o_ppy_reg, o_ppx_reg,
                        o_vy_reg, o_vx_reg, o_py_reg, o_px_reg};
    assign m_tuser   = {out_sat_reg, out_dclamp_reg};

endmodule

[rtl/kt_checker.sv]
// port-level checks for the kalman tracker, bound to the top level
// depends on kalman_tracker_constant_velocity_2d_unit_assert.svh
module kt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [415:0] m_tdata,
    input logic [1:0]   m_tuser
);
`include "kalman_tracker_constant_velocity_2d_unit_assert.svh"

    `KT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `KT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `KT_ASSERT_NOW(a_result_from_busy, $rose(m_tvalid), $past(!s_tready), "result while idle")

endmodule

bind kalman_tracker_constant_velocity_2d_unit kt_checker u_kt_checker (.*);
